// ===== hw/rtl/qct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_pkg
// Shared types and constants for the qcow2 cluster translator.
// ----------------------------------------------------------------------------
package qct_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_CLUSTER_SHIFT = 2'd0;
  localparam logic [1:0] REG_L1_OFFSET     = 2'd1;
  localparam logic [1:0] REG_L1_COUNT      = 2'd2;

  // input operation codes
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // cluster size limits (log2 bytes)
  localparam logic [4:0] CB_MIN   = 5'd9;
  localparam logic [4:0] CB_MAX   = 5'd21;
  localparam logic [4:0] CB_RESET = 5'd16;

  // longest request in sectors
  localparam int unsigned MAX_SECTORS = 64;

  // kind of result for one piece
  typedef enum logic [1:0] {
    KIND_MAPPED,
    KIND_UNMAPPED,
    KIND_FAULT
  } qct_kind_t;

  // controller to datapath commands
  typedef struct packed {
    logic      wr_en;      // store one table word
    logic      req_start;  // latch a translate request
    logic      split;      // register piece geometry
    logic      rd_l2;      // table read address from L2 entry
    logic      emit;       // register and show one result
    qct_kind_t kind;
  } qct_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic req_empty;   // zero sector count
    logic l1_bad;      // L1 index out of range or outside memory
    logic l2_zero;     // L1 entry gives zero table offset
    logic l2_bad;      // L2 word outside memory
    logic clus_zero;   // L2 entry gives zero cluster
    logic last_piece;  // this piece ends the request
  } qct_sts_t;

  // byte reverse of one table word
  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/qct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_ctrl
// Request sequencer: walks each piece through split, L1 and L2 lookup.
// ----------------------------------------------------------------------------
module qct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_operation,
  input  qct_pkg::qct_sts_t sts,
  output qct_pkg::qct_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import qct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_L1,
    S_L2
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  // next state and commands
  always_comb begin
    logic do_emit;
    do_emit   = 1'b0;
    cmd       = '0;
    cmd.kind  = KIND_MAPPED;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_LOAD) begin
            cmd.wr_en = 1'b1;
          end else if (!sts.req_empty) begin
            cmd.req_start = 1'b1;
            state_nxt     = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        if (sts.l1_bad) begin
          do_emit  = 1'b1;
          cmd.kind = KIND_FAULT;
        end else begin
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        cmd.rd_l2 = 1'b1;
        if (sts.l2_zero) begin
          do_emit  = 1'b1;
          cmd.kind = KIND_UNMAPPED;
        end else if (sts.l2_bad) begin
          do_emit  = 1'b1;
          cmd.kind = KIND_FAULT;
        end else begin
          state_nxt = S_L2;
        end
      end
      S_L2: begin
        do_emit  = 1'b1;
        cmd.kind = sts.clus_zero ? KIND_UNMAPPED : KIND_MAPPED;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // a finished piece moves on to the next one or ends the request
    if (do_emit) begin
      cmd.emit  = 1'b1;
      state_nxt = sts.last_piece ? S_IDLE : S_SPLIT;
    end
    valid_nxt = do_emit;
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// ===== hw/rtl/qct_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_datapath
// Configuration registers, table memory, piece geometry, entry decode
// and result registers.
// ----------------------------------------------------------------------------
module qct_datapath #(
  parameter int IMAGE_WORDS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qct_pkg::qct_cmd_t cmd,
  output qct_pkg::qct_sts_t sts,
  input  logic [11:0]       in_word_address,
  input  logic [63:0]       in_word_value,
  input  logic [54:0]       in_start_sector,
  input  logic [6:0]        in_sector_count,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [14:0]       cfg_wdata,
  output logic [61:0]       out_host_offset,
  output logic [63:0]       out_guest_offset,
  output logic [15:0]       out_piece_length,
  output logic              out_unmapped,
  output logic              out_fault,
  output logic              out_last
);
  import qct_pkg::*;

  localparam int          AW      = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;
  localparam logic [63:0] DEPTH64 = 64'(IMAGE_WORDS);
  localparam logic [6:0]  MAX_CNT = 7'(MAX_SECTORS);

  // configuration
  logic [4:0]  cfg_cluster_shift_r;
  logic [14:0] cfg_l1_base_r;
  logic [12:0] cfg_l1_count_r;

  // request and piece registers
  logic [4:0]  cb_r;
  logic [63:0] offset_r;
  logic [15:0] remain_r;
  logic [20:0] in_cl_r;
  logic [17:0] l2_idx_r;
  logic [15:0] len_r;

  // result registers
  logic [61:0] host_r;
  logic [63:0] guest_r;
  logic [15:0] plen_r;
  logic        unm_r;
  logic        flt_r;
  logic        last_r;

  // memory interface
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;
  logic [63:0]   waddr64;

  // combinational signals
  logic [4:0]  cb_sat;
  logic [6:0]  cnt_sat;
  logic [21:0] csize;
  logic [20:0] in_cl;
  logic [21:0] room;
  logic [15:0] len_comb;
  logic [15:0] len_use;
  logic [63:0] cidx;
  logic [4:0]  l2b;
  logic [17:0] l2_idx;
  logic [5:0]  l1_sh;
  logic [63:0] l1_slot;
  logic        idx_bad;
  logic [13:0] l1_addr;
  logic [63:0] l1_addr64;
  logic [63:0] swapped;
  logic [62:0] l2off;
  logic [60:0] l2_addr;
  logic [63:0] l2_addr64;
  logic [61:0] clus;
  logic [61:0] host;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cluster_shift_r <= CB_RESET;
      cfg_l1_base_r       <= '0;
      cfg_l1_count_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLUSTER_SHIFT: cfg_cluster_shift_r <= cfg_wdata[4:0];
        REG_L1_OFFSET:     cfg_l1_base_r       <= cfg_wdata;
        REG_L1_COUNT:      cfg_l1_count_r      <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // request setup: clamp cluster size and sector count
  assign cb_sat  = (cfg_cluster_shift_r < CB_MIN) ? CB_MIN :
                   (cfg_cluster_shift_r > CB_MAX) ? CB_MAX : cfg_cluster_shift_r;
  assign cnt_sat = (in_sector_count > MAX_CNT) ? MAX_CNT : in_sector_count;

  // piece geometry: offset in cluster and length up to cluster end
  assign csize    = 22'd1 << cb_r;
  assign in_cl    = offset_r[20:0] & (csize[20:0] - 21'd1);
  assign room     = csize - {1'b0, in_cl};
  assign len_comb = (room > {6'd0, remain_r}) ? remain_r : room[15:0];
  assign len_use  = cmd.split ? len_comb : len_r;

  // table indexes
  assign cidx     = offset_r >> cb_r;
  assign l2b      = cb_r - 5'd3;
  assign l2_idx   = cidx[17:0] & ((18'd1 << l2b) - 18'd1);
  assign l1_sh    = {1'b0, cb_r} + {1'b0, l2b};
  assign l1_slot  = offset_r >> l1_sh;
  assign idx_bad  = (|l1_slot[63:13]) || (l1_slot[12:0] >= cfg_l1_count_r);
  assign l1_addr  = {2'd0, cfg_l1_base_r[14:3]} + {1'b0, l1_slot[12:0]};
  assign l1_addr64 = 64'(l1_addr);

  // entry decode from the word read last cycle
  assign swapped   = swap64(ram_rdata);
  assign l2off     = swapped[62:0];
  assign l2_addr   = {1'b0, l2off[62:3]} + 61'(l2_idx_r);
  assign l2_addr64 = 64'(l2_addr);
  assign clus      = swapped[61:0];
  assign host      = clus + 62'(in_cl_r);

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.req_empty  = (in_sector_count == 7'd0);
    sts.l1_bad     = idx_bad || (l1_addr64 >= DEPTH64);
    sts.l2_zero    = (l2off == 63'd0);
    sts.l2_bad     = (l2_addr64 >= DEPTH64);
    sts.clus_zero  = (clus == 62'd0);
    sts.last_piece = (remain_r == len_use);
  end

  // table memory ports
  assign waddr64   = 64'(in_word_address);
  assign ram_we    = cmd.wr_en && (waddr64 < DEPTH64);
  assign ram_waddr = waddr64[AW-1:0];
  assign ram_raddr = cmd.rd_l2 ? l2_addr64[AW-1:0] : l1_addr64[AW-1:0];

  qct_ram #(
    .WIDTH (64),
    .DEPTH (IMAGE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request, piece and result registers
  always_ff @(posedge clk) begin
    if (cmd.req_start) begin
      cb_r     <= cb_sat;
      offset_r <= {in_start_sector, 9'd0};
      remain_r <= {cnt_sat, 9'd0};
    end
    if (cmd.split) begin
      in_cl_r  <= in_cl;
      l2_idx_r <= l2_idx;
      len_r    <= len_comb;
    end
    if (cmd.emit) begin
      host_r   <= (cmd.kind == KIND_MAPPED) ? host : 62'd0;
      guest_r  <= offset_r;
      plen_r   <= len_use;
      unm_r    <= (cmd.kind == KIND_UNMAPPED);
      flt_r    <= (cmd.kind == KIND_FAULT);
      last_r   <= sts.last_piece;
      offset_r <= offset_r + 64'(len_use);
      remain_r <= remain_r - len_use;
    end
  end

  assign out_host_offset  = host_r;
  assign out_guest_offset = guest_r;
  assign out_piece_length = plen_r;
  assign out_unmapped     = unm_r;
  assign out_fault        = flt_r;
  assign out_last         = last_r;

endmodule

// ===== hw/rtl/qcow2_cluster_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcow2_cluster_translator
// Two-level cluster table lookup of guest sector ranges in a qcow2 image.
// ----------------------------------------------------------------------------
// channel   ports                        transfer
// command   start/busy, in_*             edge with start high and busy low
// result    out_valid, out_*             every edge that ends an out_valid cycle
// config    cfg_we, cfg_index, cfg_wdata edge with cfg_we high
//
// A load gives no result; busy stays low.
// A translate runs one piece at a time: a mapped piece passes split, L1 and L2,
// set by the two dependent reads of the single-read-port table memory; a zero
// L1 entry or an L2 word outside memory ends it in L1, an L1 fault in split.
// busy drops in the cycle the last result shows, so the next command follows.
// Reset is synchronous; the table memory is not cleared.
// ----------------------------------------------------------------------------
module qcow2_cluster_translator #(
  parameter int IMAGE_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [11:0] in_word_address,
  input  logic [63:0] in_word_value,
  input  logic [54:0] in_start_sector,
  input  logic [6:0]  in_sector_count,
  output logic        out_valid,
  output logic [61:0] out_host_offset,
  output logic [63:0] out_guest_offset,
  output logic [15:0] out_piece_length,
  output logic        out_unmapped,
  output logic        out_fault,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  import qct_pkg::*;

  qct_cmd_t cmd;
  qct_sts_t sts;

  // sequencer
  qct_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  // datapath with table memory
  qct_datapath #(
    .IMAGE_WORDS (IMAGE_WORDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_word_address  (in_word_address),
    .in_word_value    (in_word_value),
    .in_start_sector  (in_start_sector),
    .in_sector_count  (in_sector_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_host_offset  (out_host_offset),
    .out_guest_offset (out_guest_offset),
    .out_piece_length (out_piece_length),
    .out_unmapped     (out_unmapped),
    .out_fault        (out_fault),
    .out_last         (out_last)
  );

endmodule

// ===== hw/rtl/qct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qct_checker
// Port-level checks of the cluster translator, bound to the top level.
// ----------------------------------------------------------------------------
module qct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_operation,
  input logic [6:0]  in_sector_count,
  input logic        out_valid,
  input logic [61:0] out_host_offset,
  input logic        out_unmapped,
  input logic        out_fault,
  input logic        out_last
);

  // a result only follows a cycle of work
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  // a non-empty translate transfer starts work
  a_translate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation && (in_sector_count != 7'd0)) |=> busy)
    else $error("translate request not started");

  // loads and empty requests give nothing and keep the block free
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_operation && (in_sector_count != 7'd0)))
      |=> (!busy && !out_valid))
    else $error("load or empty request caused activity");

  // the last piece ends the request in the same cycle
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == !busy))
    else $error("last mark and busy disagree");

  // fault and unmapped exclude each other and carry no host offset
  a_flag_host: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fault || out_unmapped))
      |-> (!(out_fault && out_unmapped) && (out_host_offset == 62'd0)))
    else $error("bad flags or host offset on unresolved piece");

endmodule

bind qcow2_cluster_translator qct_checker u_qct_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_operation    (in_operation),
  .in_sector_count (in_sector_count),
  .out_valid       (out_valid),
  .out_host_offset (out_host_offset),
  .out_unmapped    (out_unmapped),
  .out_fault       (out_fault),
  .out_last        (out_last)
);
